@@ src/cwd_pkg.sv @@
package cwd_pkg;

    // Accumulator width of the shared multiply-accumulate unit
    localparam int ACC_W = 64;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_INPUT_GAIN     = 3'd0;
    localparam logic [2:0] REG_THRESHOLD_DB   = 3'd1;
    localparam logic [2:0] REG_SLOPE          = 3'd2;
    localparam logic [2:0] REG_ATTACK_COEFF   = 3'd3;
    localparam logic [2:0] REG_RELEASE_COEFF  = 3'd4;
    localparam logic [2:0] REG_DEESS_ENABLE   = 3'd5;
    localparam logic [2:0] REG_DEESS_THR_DB   = 3'd6;
    localparam logic [2:0] REG_DEESS_MAX_CUT  = 3'd7;

    // Fixed-point constants
    localparam int EPS_Q27      = 134;
    localparam int DB_PER_LOG2  = 394567;
    localparam int LOG2_PER_DB  = 2786635;
    localparam int FLOOR_DB     = -25600;
    localparam int COMP_MAX_CUT = 6144;

    // Cubic for 2^-f, Q1.28
    localparam logic [28:0] POLY_C1  = 29'd186028455;
    localparam logic [28:0] POLY_C2  = 29'd63509144;
    localparam logic [28:0] POLY_C3  = 29'd11698417;
    localparam logic [28:0] POLY_ONE = 29'd268435456;

    // Operation of the multiply-accumulate unit
    typedef struct packed {
        logic en;
        logic add;
    } mac_op_t;

    // Horner coefficient used after step k
    function automatic logic [28:0] poly_coeff(input logic [1:0] k);
        logic [28:0] c;
        case (k)
            2'd0:    c = POLY_C2;
            2'd1:    c = POLY_C1;
            default: c = POLY_ONE;
        endcase
        return c;
    endfunction

endpackage

@@ src/cwd_mac.sv @@
// Shared signed multiplier with accumulator
module cwd_mac #(
    parameter int OPW = 34
) (
    input  logic                              clk,
    input  cwd_pkg::mac_op_t                  op,
    input  logic signed [OPW-1:0]             a,
    input  logic signed [OPW-1:0]             b,
    output logic signed [cwd_pkg::ACC_W-1:0]  acc
);

    logic signed [2*OPW-1:0]           prod;
    logic signed [cwd_pkg::ACC_W-1:0]  acc_reg;

    assign prod = a * b;
    assign acc  = acc_reg;

    // load or accumulate the product
    always_ff @(posedge clk)
    begin
        if (op.en)
        begin
            acc_reg <= (op.add ? acc_reg : '0) + cwd_pkg::ACC_W'(prod);
        end
    end

endmodule

@@ src/compressor_with_deesser.sv @@
// Feed-forward compressor with optional de-esser for two channels. A sample
// transfers in on s_* with its channel in s_tuser; the processed sample transfers out
// on m_* with the same channel. All multiplications run on one shared
// multiply-accumulate unit under a sequencer. After a transfer in, s_tready stays
// low until the result is loaded into the output register, after which the
// sequencer returns to idle and takes the next transfer. Most of the work is the
// log conversion (16 squaring steps for each stage), which is skipped when an
// envelope is zero. A stalled receiver adds its stall cycles only when the
// previous result still waits. s_tready is high only while the sequencer is
// idle. The output register lets the next sample start while a result still
// waits. Envelope and lowpass state is reset to zero. Configuration must be
// written while idle.
module compressor_with_deesser #(
    parameter int CHANNELS            = 2,
    parameter int SAMPLE_BITS         = 24,
    parameter int DEESS_LOWPASS_COEFF = 10611589,
    parameter int DEESS_ATTACK_COEFF  = 16707456,
    parameter int DEESS_RELEASE_COEFF = 16772848,
    localparam int TDATA_W            = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // sample_in
    input  logic               s_tuser,   // channel
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // sample_out
    output logic               m_tuser,   // channel_out
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data
);

    localparam int YW    = SAMPLE_BITS + 4;
    localparam int OPW   = (SAMPLE_BITS + 6 > 34) ? SAMPLE_BITS + 6 : 34;
    localparam int FRAC  = SAMPLE_BITS - 1;
    localparam int Q_L   = (FRAC <= 27) ? 27 - FRAC : 0;
    localparam int Q_R   = (FRAC > 27) ? FRAC - 27 : 0;
    localparam int CH_IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ACCW  = cwd_pkg::ACC_W;

    // Sequencer states
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_GAIN  = 5'd1;
    localparam logic [4:0] S_GAINR = 5'd2;
    localparam logic [4:0] S_MAG   = 5'd3;
    localparam logic [4:0] S_ENV1  = 5'd4;
    localparam logic [4:0] S_ENV2  = 5'd5;
    localparam logic [4:0] S_ENV3  = 5'd6;
    localparam logic [4:0] S_LOG0  = 5'd7;
    localparam logic [4:0] S_NORM  = 5'd8;
    localparam logic [4:0] S_SQ    = 5'd9;
    localparam logic [4:0] S_SQN   = 5'd10;
    localparam logic [4:0] S_DB    = 5'd11;
    localparam logic [4:0] S_DBR   = 5'd12;
    localparam logic [4:0] S_OVER  = 5'd13;
    localparam logic [4:0] S_GR    = 5'd14;
    localparam logic [4:0] S_CUT0  = 5'd15;
    localparam logic [4:0] S_CUT1  = 5'd16;
    localparam logic [4:0] S_PMUL  = 5'd17;
    localparam logic [4:0] S_PSUB  = 5'd18;
    localparam logic [4:0] S_GN    = 5'd19;
    localparam logic [4:0] S_APPLY = 5'd20;
    localparam logic [4:0] S_APR   = 5'd21;
    localparam logic [4:0] S_DE0   = 5'd22;
    localparam logic [4:0] S_LP1   = 5'd23;
    localparam logic [4:0] S_LP2   = 5'd24;
    localparam logic [4:0] S_LP3   = 5'd25;
    localparam logic [4:0] S_HB    = 5'd26;
    localparam logic [4:0] S_OUT   = 5'd27;

    logic [4:0] state_reg, state_next;

    // Configuration
    logic [15:0]        gain_cfg_reg;
    logic signed [14:0] thr_reg;
    logic [15:0]        slope_reg;
    logic [23:0]        att_reg;
    logic [23:0]        rel_reg;
    logic               de_en_reg;
    logic signed [13:0] de_thr_reg;
    logic [11:0]        de_cut_reg;

    // Per-channel state
    logic [31:0]        cenv_reg [CHANNELS];
    logic signed [31:0] lp_store_reg [CHANNELS];
    logic [31:0]        denv_reg [CHANNELS];

    // Working registers
    logic                          phase_reg;
    logic                          ch_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [YW-1:0]          y_reg;
    logic [31:0]                   mag_reg;
    logic [31:0]                   env_reg;
    logic [23:0]                   c_reg;
    logic [31:0]                   nrm_reg;
    logic [4:0]                    p_reg;
    logic [2:0]                    sh_reg;
    logic [31:0]                   m_reg;
    logic [15:0]                   frac_reg;
    logic [3:0]                    cnt_reg;
    logic signed [15:0]            db_reg;
    logic [12:0]                   cut_reg;
    logic [2:0]                    n_reg;
    logic [15:0]                   f_reg;
    logic [28:0]                   poly_reg;
    logic [1:0]                    k_reg;
    logic [12:0]                   gain_reg;
    logic signed [OPW-1:0]         y27_reg;
    logic signed [31:0]            lp_reg;

    // Output register
    logic                   out_valid_reg;
    logic                   out_ch_reg;
    logic [SAMPLE_BITS-1:0] out_data_reg;

    // Shared unit
    cwd_pkg::mac_op_t       mac_op;
    logic signed [OPW-1:0]  mac_a, mac_b;
    logic signed [ACCW-1:0] acc;

    logic [CH_IW-1:0] ch_idx;
    logic             in_xfer;
    logic             out_load;

    logic signed [OPW-1:0]  y_ext, y_abs, y_q27, hb, hb_abs, hb_m;
    logic [31:0]            mag_y, mag_hb;
    logic [23:0]            att_sel, rel_sel, c_sel;
    logic [31:0]            env_new;
    logic [5:0]             kk;
    logic                   top_zero;
    logic [31:0]            nrm_shift;
    logic [4:0]             p_shift;
    logic [31:0]            sq_t;
    logic signed [22:0]     l_val;
    logic signed [ACCW-1:0] db_w, gr_w, e_w, lp_w, y_w;
    logic signed [15:0]     db_new;
    logic signed [14:0]     thr_sel;
    logic signed [16:0]     over_v;
    logic [12:0]            de_cut_sel;
    logic [12:0]            gr_cut;
    logic [29:0]            g_sh;
    logic [SAMPLE_BITS-1:0] y_sat;
    logic [4:0]             after_gain;

    assign ch_idx   = (CHANNELS == 1) ? '0 : CH_IW'(ch_reg);
    assign s_tready = (state_reg == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || m_tready);

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_ch_reg;
    assign m_tdata  = TDATA_W'(out_data_reg);

    // Magnitudes in Q5.27
    assign y_ext  = OPW'(y_reg);
    assign y_abs  = (y_ext < 0) ? -y_ext : y_ext;
    assign mag_y  = 32'(((y_abs <<< Q_L) >>> Q_R) + OPW'(cwd_pkg::EPS_Q27));
    assign y_q27  = (y_ext <<< Q_L) >>> Q_R;
    assign hb     = y27_reg - OPW'(lp_reg);
    assign hb_abs = (hb < 0) ? -hb : hb;
    assign hb_m   = hb_abs + OPW'(cwd_pkg::EPS_Q27);
    assign mag_hb = (hb_m[OPW-1:32] != '0) ? 32'hFFFF_FFFF : hb_m[31:0];

    // Envelope pole select
    assign att_sel = phase_reg ? 24'(DEESS_ATTACK_COEFF) : att_reg;
    assign rel_sel = phase_reg ? 24'(DEESS_RELEASE_COEFF) : rel_reg;
    assign c_sel   = (mag_reg > env_reg) ? att_sel : rel_sel;
    assign env_new = 32'((acc + 64'sd8388608) >>> 24);

    // Leading-one search, halving step each cycle
    assign kk        = 6'd16 >> sh_reg;
    assign top_zero  = ((nrm_reg >> (6'd32 - kk)) == 32'd0);
    assign nrm_shift = top_zero ? (nrm_reg << kk) : nrm_reg;
    assign p_shift   = top_zero ? (p_reg - 5'(kk)) : p_reg;
    assign sq_t      = acc[61:30];

    // log2 to dB
    assign l_val  = {(7'(p_reg) - 7'd27), frac_reg};
    assign db_w   = (acc + 64'sd8388608) >>> 24;
    assign db_new = (db_w < cwd_pkg::FLOOR_DB) ? 16'(cwd_pkg::FLOOR_DB) : 16'(db_w);

    // Excess over threshold and cut limits
    assign thr_sel    = phase_reg ? 15'(de_thr_reg) : thr_reg;
    assign over_v     = 17'(db_reg) - 17'(thr_sel);
    assign de_cut_sel = (over_v > $signed({5'b0, de_cut_reg})) ? 13'(de_cut_reg)
                                                               : 13'(over_v);
    assign gr_w       = (acc + 64'sd32768) >>> 16;
    assign gr_cut     = (gr_w > cwd_pkg::COMP_MAX_CUT) ? 13'(cwd_pkg::COMP_MAX_CUT)
                                                       : 13'(gr_w);
    assign e_w        = (acc + 64'sd32768) >>> 16;
    assign g_sh       = (30'(poly_reg) >> n_reg) + 30'd32768;
    assign y_w        = (acc + 64'sd2048) >>> 12;
    assign lp_w       = (acc + 64'sd8388608) >>> 24;

    assign after_gain = (!phase_reg && de_en_reg) ? S_DE0 : S_OUT;

    // Output saturation
    always_comb
    begin
        if ((y_reg[YW-1:SAMPLE_BITS-1] == '0) || (y_reg[YW-1:SAMPLE_BITS-1] == '1))
        begin
            y_sat = y_reg[SAMPLE_BITS-1:0];
        end
        else
        begin
            y_sat = y_reg[YW-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    // Multiplier operand selection
    always_comb
    begin
        mac_op = '0;
        mac_a  = '0;
        mac_b  = '0;
        case (state_reg)
            S_GAIN:
            begin
                mac_op.en = 1'b1;
                mac_a     = OPW'(x_reg);
                mac_b     = OPW'($signed({1'b0, gain_cfg_reg}));
            end
            S_ENV1:
            begin
                mac_op.en = 1'b1;
                mac_a     = OPW'($signed({1'b0, c_sel}));
                mac_b     = OPW'($signed({1'b0, env_reg}));
            end
            S_ENV2:
            begin
                mac_op.en  = 1'b1;
                mac_op.add = 1'b1;
                mac_a      = OPW'($signed(26'h100_0000 - {2'b0, c_reg}));
                mac_b      = OPW'($signed({1'b0, mag_reg}));
            end
            S_SQ:
            begin
                mac_op.en = 1'b1;
                mac_a     = OPW'($signed({1'b0, m_reg}));
                mac_b     = OPW'($signed({1'b0, m_reg}));
            end
            S_DB:
            begin
                mac_op.en = 1'b1;
                mac_a     = OPW'(l_val);
                mac_b     = OPW'(cwd_pkg::DB_PER_LOG2);
            end
            S_OVER:
            begin
                mac_op.en = !phase_reg;
                mac_a     = OPW'(over_v);
                mac_b     = OPW'($signed({1'b0, slope_reg}));
            end
            S_CUT0:
            begin
                mac_op.en = 1'b1;
                mac_a     = OPW'($signed({1'b0, cut_reg}));
                mac_b     = OPW'(cwd_pkg::LOG2_PER_DB);
            end
            S_PMUL:
            begin
                mac_op.en = 1'b1;
                mac_a     = OPW'($signed({1'b0, poly_reg}));
                mac_b     = OPW'($signed({1'b0, f_reg}));
            end
            S_APPLY:
            begin
                mac_op.en = 1'b1;
                mac_a     = y_ext;
                mac_b     = OPW'($signed({1'b0, gain_reg}));
            end
            S_LP1:
            begin
                mac_op.en = 1'b1;
                mac_a     = OPW'(DEESS_LOWPASS_COEFF);
                mac_b     = OPW'(lp_reg);
            end
            S_LP2:
            begin
                mac_op.en  = 1'b1;
                mac_op.add = 1'b1;
                mac_a      = OPW'(16777216 - DEESS_LOWPASS_COEFF);
                mac_b      = y27_reg;
            end
            default:
            begin
                mac_op = '0;
            end
        endcase
    end

    cwd_mac #(
        .OPW (OPW)
    ) u_mac (
        .clk (clk),
        .op  (mac_op),
        .a   (mac_a),
        .b   (mac_b),
        .acc (acc)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  state_next = in_xfer ? S_GAIN : S_IDLE;
            S_GAIN:  state_next = S_GAINR;
            S_GAINR: state_next = S_MAG;
            S_MAG:   state_next = S_ENV1;
            S_ENV1:  state_next = S_ENV2;
            S_ENV2:  state_next = S_ENV3;
            S_ENV3:  state_next = S_LOG0;
            S_LOG0:  state_next = (env_reg == 32'd0) ? S_OVER : S_NORM;
            S_NORM:  state_next = (sh_reg == 3'd4) ? S_SQ : S_NORM;
            S_SQ:    state_next = S_SQN;
            S_SQN:   state_next = (cnt_reg == 4'd15) ? S_DB : S_SQ;
            S_DB:    state_next = S_DBR;
            S_DBR:   state_next = S_OVER;
            S_OVER:
            begin
                if (over_v > 0)
                begin
                    state_next = phase_reg ? S_CUT0 : S_GR;
                end
                else
                begin
                    state_next = after_gain;
                end
            end
            S_GR:    state_next = S_CUT0;
            S_CUT0:  state_next = S_CUT1;
            S_CUT1:  state_next = S_PMUL;
            S_PMUL:  state_next = S_PSUB;
            S_PSUB:  state_next = (k_reg == 2'd2) ? S_GN : S_PMUL;
            S_GN:    state_next = S_APPLY;
            S_APPLY: state_next = S_APR;
            S_APR:   state_next = after_gain;
            S_DE0:   state_next = S_LP1;
            S_LP1:   state_next = S_LP2;
            S_LP2:   state_next = S_LP3;
            S_LP3:   state_next = S_HB;
            S_HB:    state_next = S_ENV1;
            S_OUT:   state_next = out_load ? S_IDLE : S_OUT;
            default: state_next = S_IDLE;
        endcase
    end

    // Control, configuration and channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
            gain_cfg_reg  <= 16'd4096;
            thr_reg       <= -15'sd5760;
            slope_reg     <= 16'd52429;
            att_reg       <= 24'd16723530;
            rel_reg       <= 24'd16776245;
            de_en_reg     <= 1'b0;
            de_thr_reg    <= -14'sd6144;
            de_cut_reg    <= 12'd2560;
            for (int i = 0; i < CHANNELS; i++)
            begin
                cenv_reg[i]     <= '0;
                lp_store_reg[i] <= '0;
                denv_reg[i]     <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            // output register
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            // stage select
            if (in_xfer)
            begin
                phase_reg <= 1'b0;
            end
            else if (state_reg == S_DE0)
            begin
                phase_reg <= 1'b1;
            end

            // store write-back
            if (state_reg == S_ENV3)
            begin
                if (phase_reg)
                begin
                    denv_reg[ch_idx] <= env_new;
                end
                else
                begin
                    cenv_reg[ch_idx] <= env_new;
                end
            end
            if (state_reg == S_LP3)
            begin
                lp_store_reg[ch_idx] <= 32'(lp_w);
            end

            // configuration writes
            if (cfg_we)
            begin
                case (cfg_index)
                    cwd_pkg::REG_INPUT_GAIN:    gain_cfg_reg <= cfg_data[15:0];
                    cwd_pkg::REG_THRESHOLD_DB:  thr_reg      <= cfg_data[14:0];
                    cwd_pkg::REG_SLOPE:         slope_reg    <= cfg_data[15:0];
                    cwd_pkg::REG_ATTACK_COEFF:  att_reg      <= cfg_data[23:0];
                    cwd_pkg::REG_RELEASE_COEFF: rel_reg      <= cfg_data[23:0];
                    cwd_pkg::REG_DEESS_ENABLE:  de_en_reg    <= cfg_data[0];
                    cwd_pkg::REG_DEESS_THR_DB:  de_thr_reg   <= cfg_data[13:0];
                    cwd_pkg::REG_DEESS_MAX_CUT: de_cut_reg   <= cfg_data[11:0];
                    default:                    de_cut_reg   <= de_cut_reg;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    x_reg  <= s_tdata[SAMPLE_BITS-1:0];
                    ch_reg <= s_tuser;
                end
            end
            S_GAINR:
            begin
                y_reg <= YW'(y_w);
            end
            S_MAG:
            begin
                mag_reg <= mag_y;
                env_reg <= cenv_reg[ch_idx];
            end
            S_ENV1:
            begin
                c_reg <= c_sel;
            end
            S_ENV3:
            begin
                env_reg <= env_new;
            end
            S_LOG0:
            begin
                nrm_reg <= env_reg;
                p_reg   <= 5'd31;
                sh_reg  <= 3'd0;
                db_reg  <= 16'(cwd_pkg::FLOOR_DB);
            end
            S_NORM:
            begin
                nrm_reg  <= nrm_shift;
                p_reg    <= p_shift;
                sh_reg   <= sh_reg + 3'd1;
                m_reg    <= {1'b0, nrm_shift[31:1]};
                frac_reg <= '0;
                cnt_reg  <= '0;
            end
            S_SQN:
            begin
                m_reg    <= sq_t[31] ? (sq_t >> 1) : sq_t;
                frac_reg <= {frac_reg[14:0], sq_t[31]};
                cnt_reg  <= cnt_reg + 4'd1;
            end
            S_DBR:
            begin
                db_reg <= db_new;
            end
            S_OVER:
            begin
                cut_reg <= de_cut_sel;
            end
            S_GR:
            begin
                cut_reg <= gr_cut;
            end
            S_CUT1:
            begin
                n_reg    <= e_w[18:16];
                f_reg    <= e_w[15:0];
                poly_reg <= cwd_pkg::POLY_C3;
                k_reg    <= 2'd0;
            end
            S_PSUB:
            begin
                poly_reg <= cwd_pkg::poly_coeff(k_reg) - 29'(acc >>> 16);
                k_reg    <= k_reg + 2'd1;
            end
            S_GN:
            begin
                gain_reg <= 13'(g_sh >> 16);
            end
            S_APR:
            begin
                y_reg <= YW'(y_w);
            end
            S_DE0:
            begin
                y27_reg <= y_q27;
                lp_reg  <= lp_store_reg[ch_idx];
            end
            S_LP3:
            begin
                lp_reg <= 32'(lp_w);
            end
            S_HB:
            begin
                mag_reg <= mag_hb;
                env_reg <= denv_reg[ch_idx];
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    out_data_reg <= y_sat;
                    out_ch_reg   <= ch_reg;
                end
            end
            default:
            begin
                y_reg <= y_reg;
            end
        endcase
    end

endmodule

@@ src/cwd_chk.sv @@
// Port-level checks for the compressor
module cwd_chk #(
    parameter int TDATA_W = 24
) (
    input logic               clk,
    input logic               rst_n,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic               m_tuser
);

    // a transfer in keeps the block busy, so s_tready drops after it
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready ##1 !s_tready)
    else $error("input accepted again too soon");

    // a result appears only after the block has been busy
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result without processing");

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind compressor_with_deesser cwd_chk #(.TDATA_W(TDATA_W)) u_cwd_chk (.*);

@@ verif/tb_compressor_with_deesser.sv @@
module tb_compressor_with_deesser;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint DE_LP  = 10611589;
    localparam longint DE_ATT = 16707456;
    localparam longint DE_REL = 16772848;
    localparam longint PC1 = 186028455;
    localparam longint PC2 = 63509144;
    localparam longint PC3 = 11698417;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // sample_in
    logic        s_tuser;   // channel
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // sample_out
    logic        m_tuser;   // channel_out
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_data;

    compressor_with_deesser u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    typedef struct packed {
        logic        chan;
        logic [23:0] smp;
    } audio_t;

    // Predictor copy of registers and per-channel state
    longint gain_q12, thr_db, slope_q16, att_c, rel_c, de_thr_db, de_cut_db;
    bit     de_on;
    longint env_comp [2];
    longint lp_de    [2];
    longint env_de   [2];

    audio_t expected_q[$];
    int     errors;
    bit     quiet;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Half-up rounding shift on signed values
    function automatic longint rnd_shr(longint x, int s);
        return (x + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint env_step(longint e, longint m, longint a, longint r);
        longint c;
        c = (m > e) ? a : r;
        return (c * e + ((longint'(1) << 24) - c) * m + (longint'(1) << 23)) >>> 24;
    endfunction

    // Envelope (Q5.27) to dB Q8.8
    function automatic longint to_db(longint raw);
        int     p;
        longint m, fr, l, d;
        if (raw == 0)
            return cwd_pkg::FLOOR_DB;
        p = 62;
        while (((raw >> p) & 1) == 0)
            p--;
        m = (p <= 30) ? (raw << (30 - p)) : (raw >> (p - 30));
        fr = 0;
        for (int i = 0; i < 16; i++)
        begin
            m = (m * m) >> 30;
            fr = fr << 1;
            if (m >= (longint'(2) << 30))
            begin
                fr = fr | 1;
                m = m >> 1;
            end
        end
        l = longint'(p - 27) * 65536 + fr;
        d = rnd_shr(l * cwd_pkg::DB_PER_LOG2, 24);
        return (d < cwd_pkg::FLOOR_DB) ? cwd_pkg::FLOOR_DB : d;
    endfunction

    // dB cut to linear gain Q4.12
    function automatic longint db_to_gain(longint cut);
        longint e, n, f, p;
        e = (cut * cwd_pkg::LOG2_PER_DB + 32768) >> 16;
        n = e >> 16;
        f = e & 16'hFFFF;
        p = PC3;
        p = PC2 - ((p * f) >> 16);
        p = PC1 - ((p * f) >> 16);
        p = (longint'(1) << 28) - ((p * f) >> 16);
        if (n > 30)
            return 0;
        p = p >> n;
        return (p + 32768) >> 16;
    endfunction

    function automatic audio_t process_sample(audio_t a);
        int     ch;
        longint x, y, mag, ov, gr, y27, hb, m;
        audio_t r;
        ch = a.chan;
        x = longint'($signed(a.smp));
        y = rnd_shr(x * gain_q12, 12);
        mag = ((y < 0) ? -y : y) * 16 + cwd_pkg::EPS_Q27;
        env_comp[ch] = env_step(env_comp[ch], mag, att_c, rel_c);
        ov = to_db(env_comp[ch]) - thr_db;
        if (ov > 0)
        begin
            gr = rnd_shr(ov * slope_q16, 16);
            if (gr > cwd_pkg::COMP_MAX_CUT)
                gr = cwd_pkg::COMP_MAX_CUT;
            y = rnd_shr(y * db_to_gain(gr), 12);
        end
        if (de_on)
        begin
            y27 = y * 16;
            lp_de[ch] = rnd_shr(DE_LP * lp_de[ch] + ((longint'(1) << 24) - DE_LP) * y27, 24);
            hb = y27 - lp_de[ch];
            m = ((hb < 0) ? -hb : hb) + cwd_pkg::EPS_Q27;
            if (m > 64'hFFFFFFFF)
                m = 64'hFFFFFFFF;
            env_de[ch] = env_step(env_de[ch], m, DE_ATT, DE_REL);
            ov = to_db(env_de[ch]) - de_thr_db;
            if (ov > 0)
            begin
                if (ov > de_cut_db)
                    ov = de_cut_db;
                y = rnd_shr(y * db_to_gain(ov), 12);
            end
        end
        if (y > 8388607)
            y = 8388607;
        if (y < -8388608)
            y = -8388608;
        r.chan = a.chan;
        r.smp = y[23:0];
        return r;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            cwd_pkg::REG_INPUT_GAIN:    gain_q12 = val[15:0];
            cwd_pkg::REG_THRESHOLD_DB:  thr_db = longint'($signed(val[14:0]));
            cwd_pkg::REG_SLOPE:         slope_q16 = val[15:0];
            cwd_pkg::REG_ATTACK_COEFF:  att_c = val;
            cwd_pkg::REG_RELEASE_COEFF: rel_c = val;
            cwd_pkg::REG_DEESS_ENABLE:  de_on = val[0];
            cwd_pkg::REG_DEESS_THR_DB:  de_thr_db = longint'($signed(val[13:0]));
            cwd_pkg::REG_DEESS_MAX_CUT: de_cut_db = val[11:0];
            default:                    de_on = de_on;
        endcase
    endtask

    // Drive one sample; an expected of known value is used instead of the predictor
    task automatic send_sample(audio_t a, bit has_known, logic [23:0] known);
        audio_t r;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= a.smp;
        s_tuser <= a.chan;
        do
            @(posedge clk);
        while (!s_tready);
        r = process_sample(a);
        if (has_known)
            r.smp = known;
        expected_q.insert(expected_q.size(), r);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // Output checking and receiver stalls
    always @(posedge clk)
    begin
        audio_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("unexpected transfer: sample_out %0d", $signed(m_tdata));
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (m_tuser !== e.chan)
                begin
                    $error("channel_out: expected %0d actual %0d", e.chan, m_tuser);
                    errors++;
                end
                if (m_tdata !== e.smp)
                begin
                    $error("sample_out: expected %0d actual %0d",
                           $signed(e.smp), $signed(m_tdata));
                    errors++;
                end
            end
        end
    end

    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    // Directed rows: sample, channel, known result flag and value
    typedef struct {
        logic [23:0] smp;
        logic        chan;
        bit          known;
        logic [23:0] res;
    } row_t;

    row_t rows [] = '{
        '{24'h000000, 1'b0, 1'b1, 24'h000000},
        '{24'h000000, 1'b1, 1'b1, 24'h000000},
        '{24'h000001, 1'b0, 1'b1, 24'h000001},
        '{24'hFFFFFF, 1'b1, 1'b1, 24'hFFFFFF},
        '{24'h7FFFFF, 1'b0, 1'b0, 24'h0},
        '{24'h800000, 1'b1, 1'b0, 24'h0},
        '{24'h7FFFFF, 1'b0, 1'b0, 24'h0},
        '{24'h800000, 1'b0, 1'b0, 24'h0},
        '{24'h555555, 1'b1, 1'b0, 24'h0},
        '{24'hAAAAAA, 1'b1, 1'b0, 24'h0},
        '{24'h000000, 1'b0, 1'b0, 24'h0},
        '{24'h123456, 1'b1, 1'b0, 24'h0}
    };

    task automatic run_random(int n, bit loud);
        audio_t a;
        for (int i = 0; i < n; i++)
        begin
            a.chan = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
                0:       a.smp = 24'($urandom);
                1:       a.smp = 24'($signed($urandom_range(0, 4000)) - 2000);
                2:       a.smp = $urandom_range(0, 1)
                                 ? 24'(24'h7FFFFF - $urandom_range(0, 255))
                                 : 24'(24'h800000 + $urandom_range(0, 255));
                default: a.smp = loud ? 24'($signed($urandom_range(0, 8000000)) - 4000000)
                                      : 24'($signed($urandom_range(0, 200000)) - 100000);
            endcase
            send_sample(a, 1'b0, 24'h0);
        end
    endtask

    // Main sequence
    initial
    begin
        audio_t a;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        quiet = 1'b0;
        gain_q12 = 4096;
        thr_db = -5760;
        slope_q16 = 52429;
        att_c = 16723530;
        rel_c = 16776245;
        de_on = 1'b0;
        de_thr_db = -6144;
        de_cut_db = 2560;
        for (int c = 0; c < 2; c++)
        begin
            env_comp[c] = 0;
            lp_de[c] = 0;
            env_de[c] = 0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            a.chan = rows[i].chan;
            a.smp = rows[i].smp;
            send_sample(a, rows[i].known, rows[i].res);
        end
        drain();

        // De-esser on, extremes of the compressor settings
        write_reg(cwd_pkg::REG_DEESS_ENABLE, 24'd1);
        write_reg(cwd_pkg::REG_INPUT_GAIN, 24'd65535);
        write_reg(cwd_pkg::REG_THRESHOLD_DB, 24'(-2560));
        write_reg(cwd_pkg::REG_SLOPE, 24'd57344);
        write_reg(cwd_pkg::REG_ATTACK_COEFF, 24'd0);
        write_reg(cwd_pkg::REG_RELEASE_COEFF, 24'd16777215);
        write_reg(cwd_pkg::REG_DEESS_THR_DB, 24'(-7680));
        write_reg(cwd_pkg::REG_DEESS_MAX_CUT, 24'd3584);
        run_random(140, 1'b1);
        drain();

        // Other extremes
        write_reg(cwd_pkg::REG_INPUT_GAIN, 24'd0);
        run_random(10, 1'b1);
        drain();
        write_reg(cwd_pkg::REG_INPUT_GAIN, 24'd2048);
        write_reg(cwd_pkg::REG_THRESHOLD_DB, 24'(-8960));
        write_reg(cwd_pkg::REG_SLOPE, 24'd32768);
        write_reg(cwd_pkg::REG_ATTACK_COEFF, 24'd16777215);
        write_reg(cwd_pkg::REG_RELEASE_COEFF, 24'd0);
        write_reg(cwd_pkg::REG_DEESS_THR_DB, 24'(-4608));
        write_reg(cwd_pkg::REG_DEESS_MAX_CUT, 24'd1536);
        run_random(130, 1'b0);
        drain();

        // Back to typical values
        write_reg(cwd_pkg::REG_INPUT_GAIN, 24'd8192);
        write_reg(cwd_pkg::REG_THRESHOLD_DB, 24'(-5760));
        write_reg(cwd_pkg::REG_SLOPE, 24'd52429);
        write_reg(cwd_pkg::REG_ATTACK_COEFF, 24'd16000000);
        write_reg(cwd_pkg::REG_RELEASE_COEFF, 24'd16700000);
        write_reg(cwd_pkg::REG_DEESS_THR_DB, 24'(-6144));
        write_reg(cwd_pkg::REG_DEESS_MAX_CUT, 24'd2560);
        run_random(130, 1'b1);
        drain();

        // De-esser off, no idling at the end
        write_reg(cwd_pkg::REG_DEESS_ENABLE, 24'd0);
        run_random(70, 1'b1);
        quiet = 1'b1;
        run_random(60, 1'b1);
        drain();

        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ files.f @@
src/cwd_pkg.sv
src/cwd_mac.sv
src/compressor_with_deesser.sv
src/cwd_chk.sv
verif/tb_compressor_with_deesser.sv
